>>> sv/hcc_pkg.sv
// Shared constants for the histogram count cutoff block.
// No dependencies.
package hcc_pkg;
    localparam logic CMD_RANGE = 1'b0;
    localparam logic CMD_BIN   = 1'b1;
    localparam logic [1:0] CFG_NUM_BINS  = 2'd0;
    localparam logic [1:0] CFG_TOP_COUNT = 2'd1;
    localparam logic [10:0] NUM_BINS_RESET  = 11'd100;
    localparam logic [31:0] TOP_COUNT_RESET = 32'd1000;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
endpackage

>>> sv/histogram_count_cutoff.sv
// Histogram count cutoff: range pass, bin pass into a count memory, cutoff scan.
// A range item, or an uncounted bin item that is not last, leaves the block idle; a bin
// item for bin 0 passes the read and read-modify-write states, one that runs the serial
// divider waits in the divide state first, and no new item is taken until idle again. The
// final bin item scans and clears all MAX_BINS+1 entries and, if a range sample was seen,
// divides once more. Reset runs a clearing pass over all MAX_BINS+1 entries, input closed.
module histogram_count_cutoff
    import hcc_pkg::*;
#(
    parameter int MAX_BINS    = 1024,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] command, [VW:1] sample_value, [VW+1] masked, zero padded
    input  logic [((VALUE_WIDTH+2+7)/8)*8-1:0] s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [VW-1:0] cutoff_value, [VW] empty_res, zero padded
    output logic [((VALUE_WIDTH+1+7)/8)*8-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int VW  = VALUE_WIDTH;
    localparam int BW  = $clog2(MAX_BINS + 2);
    localparam int DEP = MAX_BINS + 1;
    localparam int RW  = VW + 1;
    localparam int NBW = $clog2(MAX_BINS + 1);
    localparam int NW  = RW + NBW + 1;
    localparam int OW  = ((VW + 1 + 7) / 8) * 8;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RMW  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_CUT  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_RD   = 3'd7;

    logic [2:0]           st_reg;
    logic [10:0]          num_bins_reg;
    logic [31:0]          top_count_reg;
    logic signed [VW-1:0] lo_reg, hi_reg;
    logic                 seen_reg;
    logic                 last_reg;
    logic [BW-1:0]        addr_reg;
    logic [BW-1:0]        pick_reg;
    logic [32:0]          cum_reg;
    logic [31:0]          mem [DEP];
    logic [31:0]          rd_reg;
    logic                 out_valid_reg;
    logic [VW-1:0]        cut_reg;
    logic                 empty_reg;
    logic                 div_start;
    logic [NW-1:0]        div_numer;
    logic                 div_done;
    logic [NW-1:0]        div_quot;
    logic [NBW-1:0]       nb;
    logic [RW-1:0]        range;
    logic signed [RW-1:0] diff;
    logic signed [VW+1:0] cut_full;
    logic                 wr_en;
    logic [BW-1:0]        wr_addr;
    logic [31:0]          wr_data;
    logic [33:0]          cum_sum;
    logic [32:0]          cum_next;
    logic                 scan_hit;
    logic [BW-1:0]        pick_next;
    logic                 cfg_wr;
    logic signed [VW-1:0] s_val;

    always_comb
    begin
        if (num_bins_reg == 11'd0)
            nb = NBW'(1);
        else if (32'(num_bins_reg) > 32'(MAX_BINS))
            nb = NBW'(MAX_BINS);
        else
            nb = NBW'(num_bins_reg);
    end

    assign s_val    = s_tdata[VW:1];
    assign range    = RW'(hi_reg) - RW'(lo_reg);
    assign diff     = RW'(s_val) - RW'(lo_reg);
    assign s_tready = (st_reg == ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    // hold the running sum at its top value; it already lies above any top_count
    assign cum_sum  = {1'b0, cum_reg} + 34'(rd_reg);
    assign cum_next = cum_sum[33] ? {33{1'b1}} : cum_sum[32:0];
    // entries above nb are cleared by the scan but left out of the sum
    assign scan_hit = (st_reg == ST_SCAN) && (addr_reg != '0)
                      && (addr_reg <= BW'(nb) + 1'b1);
    assign pick_next = (scan_hit && 33'(top_count_reg) > cum_next) ? addr_reg - 1'b1
                                                                    : pick_reg;

    always_comb
    begin
        case (paddr[2])
            CFG_NUM_BINS[0]:  prdata = 32'(num_bins_reg);
            default:          prdata = top_count_reg;
        endcase
    end

    hcc_divider #(.NW(NW), .DW(RW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (st_reg == ST_SCAN ? RW'(nb) : range),
        .done  (div_done),
        .quot  (div_quot)
    );

    // divider start: bin index on an accepted counted bin item above lo, cutoff at the end of the scan
    always_comb
    begin
        div_start = 1'b0;
        div_numer = NW'(diff[RW-2:0]) * NW'(nb);
        if (st_reg == ST_IDLE && s_tvalid && s_tdata[0] == CMD_BIN && !s_tdata[VW+1]
            && seen_reg && range != '0 && !diff[RW-1] && diff != '0)
            div_start = 1'b1;
        if (st_reg == ST_SCAN && addr_reg == BW'(DEP) && seen_reg)
        begin
            div_start = 1'b1;
            div_numer = NW'(pick_next + 1'b1) * NW'(range);
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        case (st_reg)
            ST_CLR:  wr_en = 1'b1;
            ST_RMW:
            begin
                wr_en   = 1'b1;
                wr_data = (rd_reg == COUNT_MAX) ? rd_reg : rd_reg + 1'b1;
            end
            ST_SCAN:
                if (addr_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_reg - 1'b1;
                end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[addr_reg];
    end

    assign cut_full = (VW+2)'(lo_reg) + (VW+2)'($signed({1'b0, div_quot[RW-1:0]}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLR;
            num_bins_reg  <= NUM_BINS_RESET;
            top_count_reg <= TOP_COUNT_RESET;
            lo_reg        <= {1'b0, {(VW-1){1'b1}}};
            hi_reg        <= {1'b1, {(VW-1){1'b0}}};
            seen_reg      <= 1'b0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            cum_reg       <= '0;
            pick_reg      <= '0;
            cut_reg       <= '0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == CFG_NUM_BINS[0])
                num_bins_reg <= pwdata[10:0];
            if (cfg_wr && paddr[2] == CFG_TOP_COUNT[0])
                top_count_reg <= pwdata;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (st_reg)
                ST_CLR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == BW'(DEP - 1))
                    begin
                        addr_reg <= '0;
                        st_reg   <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        last_reg <= s_tlast;
                        addr_reg <= '0;
                        if (s_tdata[0] == CMD_RANGE)
                        begin
                            if (!s_tdata[VW+1])
                            begin
                                if (s_val < lo_reg) lo_reg <= s_val;
                                if (s_val > hi_reg) hi_reg <= s_val;
                                seen_reg <= 1'b1;
                            end
                        end
                        else if (!s_tdata[VW+1] && seen_reg)
                            st_reg <= div_start ? ST_DIV : ST_RD;
                        else if (s_tlast)
                        begin
                            st_reg  <= ST_SCAN;
                            cum_reg <= '0;
                            pick_reg <= '0;
                        end
                    end
                end
                ST_DIV:
                    if (div_done)
                    begin
                        addr_reg <= (div_quot > NW'(nb)) ? BW'(nb) : BW'(div_quot);
                        st_reg   <= ST_RD;
                    end
                ST_RD: st_reg <= ST_RMW;
                ST_RMW:
                begin
                    addr_reg <= '0;
                    if (last_reg)
                    begin
                        st_reg   <= ST_SCAN;
                        cum_reg  <= '0;
                        pick_reg <= '0;
                    end
                    else
                        st_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    // rd_reg holds entry addr_reg-1; accumulate and clear it
                    if (scan_hit)
                        cum_reg <= cum_next;
                    pick_reg <= pick_next;
                    if (addr_reg == BW'(DEP))
                        st_reg <= seen_reg ? ST_CUT : ST_OUT;
                    else
                        addr_reg <= addr_reg + 1'b1;
                end
                ST_CUT:
                    if (div_done)
                        st_reg <= ST_OUT;
                ST_OUT:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        empty_reg     <= !seen_reg;
                        if (!seen_reg)
                            cut_reg <= '0;
                        else if (cut_full > (VW+2)'(hi_reg) && cut_full[VW+1:VW-1] != 3'b000
                                 && !cut_full[VW+1])
                            cut_reg <= {1'b0, {(VW-1){1'b1}}};
                        else
                            cut_reg <= cut_full[VW-1:0];
                        lo_reg   <= {1'b0, {(VW-1){1'b1}}};
                        hi_reg   <= {1'b1, {(VW-1){1'b0}}};
                        seen_reg <= 1'b0;
                        addr_reg <= '0;
                        st_reg   <= ST_IDLE;
                    end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OW'({empty_reg, cut_reg});

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_no_accept_clr;
        @(posedge clk) disable iff (!rst_n)
        st_reg == ST_CLR |-> !s_tready;
    endproperty
    a_no_accept_clr: assert property (p_no_accept_clr) else $error("accept in clear");

    property p_div_scan;
        @(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == ST_DIV || st_reg == ST_CUT);
    endproperty
    a_div_scan: assert property (p_div_scan) else $error("stray divide");
endmodule

>>> sv/hcc_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses hcc_pkg.
module hcc_divider
    import hcc_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 33
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   r_shift;
    logic [DW:0]   r_sub;

    assign r_shift = {r_reg[DW-1:0], q_reg[NW-1]};
    assign r_sub   = r_shift - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= numer;
            r_reg <= '0;
            d_reg <= denom;
        end
        else if (busy_reg)
        begin
            if (!r_sub[DW])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
